@@ hw/rtl/rprf_pkg.sv @@
// shared types, constants and helper functions for the repulsion force sum block
`timescale 1ns / 1ps
package rprf_pkg;

  localparam int unsigned NumTypesDef  = 4;
  localparam int unsigned IdealNbrDef  = 4;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned InDataW      = 128;
  localparam int unsigned InUserW      = 5;
  localparam int unsigned OutDataW     = 80;
  localparam int unsigned SqrtSteps    = 32;
  localparam int unsigned DivSteps     = 62;
  localparam int unsigned IterW        = 6;

  localparam logic [30:0] RadiusRst = 31'd65536;
  localparam logic [31:0] ScaleRst  = 32'h0001_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ADH_LOW     = 3'd0,
    CFG_ADH_HIGH    = 3'd1,
    CFG_RADIUS      = 3'd2,
    CFG_ANISO_X     = 3'd3,
    CFG_ANISO_Y     = 3'd4,
    CFG_ANISO_SCALE = 3'd5,
    CFG_INITING     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic sq_x;
    logic sq_y;
    logic r_sq;
    logic sqrt_init;
    logic sqrt_step;
    logic num_load;
    logic div_step;
    logic mq;
    logic tlo;
    logic thi;
    logic sgn;
    logic axis;
    logic zero_contrib;
    logic coin_contrib;
    logic acc_add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic coincident;
    logic in_box;
    logic in_radius;
  } sts_t;

  function automatic logic [1:0] clamp_kind(logic [1:0] k, int unsigned nt);
    logic [1:0] r;
    r = (int'(k) >= int'(nt)) ? 2'(nt - 1) : k;
    return r;
  endfunction

  // entry (p,q) sits at byte 4p+q of the 128-bit table
  function automatic logic [7:0] adh_entry(logic [63:0] lo, logic [63:0] hi,
                                           logic [1:0] p, logic [1:0] q,
                                           int unsigned nt);
    logic [3:0]  idx;
    logic [63:0] row;
    idx = {clamp_kind(p, nt), clamp_kind(q, nt)};
    row = idx[3] ? hi : lo;
    return row[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

@@ hw/rtl/rprf_ctrl.sv @@
// sequencing state machine for the repulsion force sum block
`timescale 1ns / 1ps
module rprf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rprf_pkg::sts_t sts_i,
  output rprf_pkg::cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLASS = 14'b00000000000010,
    S_SQY   = 14'b00000000000100,
    S_RSQ   = 14'b00000000001000,
    S_CMP   = 14'b00000000010000,
    S_SQRT  = 14'b00000000100000,
    S_NUM   = 14'b00000001000000,
    S_DIV   = 14'b00000010000000,
    S_MQ    = 14'b00000100000000,
    S_TL    = 14'b00001000000000,
    S_TH    = 14'b00010000000000,
    S_SGN   = 14'b00100000000000,
    S_ADD   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  state_e                         state_q, state_d;
  logic [rprf_pkg::IterW-1:0]     cnt_q, cnt_d;
  logic                           axis_q, axis_d;
  logic                           ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    axis_d   = axis_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    cmd_o.axis = axis_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.sq_x = 1'b1;
        if (sts_i.skip) begin
          state_d = S_FIN;
        end else if (sts_i.coincident) begin
          cmd_o.coin_contrib = 1'b1;
          state_d = S_ADD;
        end else if (!sts_i.in_box) begin
          cmd_o.zero_contrib = 1'b1;
          state_d = S_ADD;
        end else begin
          state_d = S_SQY;
        end
      end
      S_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d = S_RSQ;
      end
      S_RSQ: begin
        cmd_o.r_sq = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.in_radius) begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d   = rprf_pkg::IterW'(rprf_pkg::SqrtSteps - 1);
          state_d = S_SQRT;
        end else begin
          cmd_o.zero_contrib = 1'b1;
          state_d = S_ADD;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          axis_d  = 1'b0;
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        cmd_o.num_load = 1'b1;
        cnt_d   = rprf_pkg::IterW'(rprf_pkg::DivSteps - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_MQ;
      end
      S_MQ: begin
        cmd_o.mq = 1'b1;
        state_d = S_TL;
      end
      S_TL: begin
        cmd_o.tlo = 1'b1;
        state_d = S_TH;
      end
      S_TH: begin
        cmd_o.thi = 1'b1;
        state_d = S_SGN;
      end
      S_SGN: begin
        cmd_o.sgn = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_NUM;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.acc_add = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (!ovalid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      axis_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      axis_q   <= axis_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

@@ hw/rtl/rprf_dpath.sv @@
// datapath: configuration, root and divide iterations, multipliers, accumulators
`timescale 1ns / 1ps
module rprf_dpath #(
  parameter int unsigned NUM_TYPES       = rprf_pkg::NumTypesDef,
  parameter int unsigned IDEAL_NEIGHBORS = rprf_pkg::IdealNbrDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rprf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rprf_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [rprf_pkg::InDataW-1:0]      in_tdata_i,
  input  logic [rprf_pkg::InUserW-1:0]      in_tuser_i,
  input  logic                              in_tlast_i,
  input  rprf_pkg::cmd_t                    cmd_i,
  output rprf_pkg::sts_t                    sts_o,
  output logic [rprf_pkg::OutDataW-1:0]     out_tdata_o
);

  // configuration
  logic [63:0] adh_lo_q, adh_hi_q;
  logic [30:0] radius_q;
  logic [31:0] ani_x_q, ani_y_q, scale_q;
  logic        initing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adh_lo_q  <= '0;
      adh_hi_q  <= '0;
      radius_q  <= rprf_pkg::RadiusRst;
      ani_x_q   <= '0;
      ani_y_q   <= '0;
      scale_q   <= rprf_pkg::ScaleRst;
      initing_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rprf_pkg::CFG_ADH_LOW:     adh_lo_q  <= cfg_wdata_i;
        rprf_pkg::CFG_ADH_HIGH:    adh_hi_q  <= cfg_wdata_i;
        rprf_pkg::CFG_RADIUS:      radius_q  <= cfg_wdata_i[30:0];
        rprf_pkg::CFG_ANISO_X:     ani_x_q   <= cfg_wdata_i[31:0];
        rprf_pkg::CFG_ANISO_Y:     ani_y_q   <= cfg_wdata_i[31:0];
        rprf_pkg::CFG_ANISO_SCALE: scale_q   <= cfg_wdata_i[31:0];
        rprf_pkg::CFG_INITING:     initing_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // capture
  logic [32:0] dx_w, dy_w;
  logic [32:0] ax_q, ay_q;
  logic        xneg_q, yneg_q, skip_q, last_q;
  logic [7:0]  a_pair_q, a_rng_q;
  logic [7:0]  a_pair_w;

  assign dx_w = {in_tdata_i[31], in_tdata_i[31:0]} - {in_tdata_i[95], in_tdata_i[95:64]};
  assign dy_w = {in_tdata_i[63], in_tdata_i[63:32]} - {in_tdata_i[127], in_tdata_i[127:96]};
  assign a_pair_w = rprf_pkg::adh_entry(adh_lo_q, adh_hi_q, in_tuser_i[1:0],
                                        in_tuser_i[3:2], NUM_TYPES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ax_q     <= dx_w[32] ? (33'd0 - dx_w) : dx_w;
      ay_q     <= dy_w[32] ? (33'd0 - dy_w) : dy_w;
      xneg_q   <= dx_w[32];
      yneg_q   <= dy_w[32];
      skip_q   <= in_tuser_i[4];
      last_q   <= in_tlast_i;
      a_pair_q <= a_pair_w;
      a_rng_q  <= initing_q ? rprf_pkg::adh_entry(adh_lo_q, adh_hi_q, 2'd0, 2'd0, NUM_TYPES)
                            : a_pair_w;
    end
  end

  // distance squared and radius squared
  logic [63:0] dsq_q, rsq_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_x) dsq_q <= ax_q[31:0] * ax_q[31:0];
    if (cmd_i.sq_y) dsq_q <= dsq_q + ay_q[31:0] * ay_q[31:0];
    if (cmd_i.r_sq) rsq_q <= {1'b0, radius_q} * {1'b0, radius_q};
  end

  // bit-pair square root
  logic [63:0] src_q;
  logic [33:0] srem_q, srem_sh, trial;
  logic [31:0] root_q;
  assign srem_sh = {srem_q[31:0], src_q[63:62]};
  assign trial   = {root_q, 2'b01};
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      src_q  <= dsq_q;
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      src_q <= {src_q[61:0], 2'b00};
      if (srem_sh >= trial) begin
        srem_q <= srem_sh - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        srem_q <= srem_sh;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  logic [30:0] dist_w;
  assign dist_w = (root_q > {1'b0, radius_q}) ? radius_q : root_q[30:0];

  // restoring divider, one quotient bit per step
  logic [61:0] dq_q;
  logic [31:0] drem_q, drem_sh;
  logic [30:0] ax_sel;
  logic [61:0] num_w;
  assign ax_sel  = cmd_i.axis ? ay_q[30:0] : ax_q[30:0];
  assign num_w   = (radius_q - dist_w) * ax_sel;
  assign drem_sh = {drem_q[30:0], dq_q[61]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.num_load) begin
      dq_q   <= num_w;
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (drem_sh >= {1'b0, dist_w}) begin
        drem_q <= drem_sh - {1'b0, dist_w};
        dq_q   <= {dq_q[60:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        dq_q   <= {dq_q[60:0], 1'b0};
      end
    end
  end

  // scaling by adhesion and gain, wrapping at 64 bits as the products do
  logic        oma_neg;
  logic [7:0]  omag;
  logic [31:0] cmag;
  logic [69:0] mq_w;
  logic [57:0] m_q;
  logic [63:0] plo_q;
  logic [57:0] phi_w;
  logic [63:0] tfull_w;
  logic [47:0] t_q;
  assign oma_neg = (a_rng_q > 8'd64);
  assign omag    = oma_neg ? (a_rng_q - 8'd64) : (8'd64 - a_rng_q);
  assign cmag    = scale_q[31] ? (32'd0 - scale_q) : scale_q;
  assign mq_w    = dq_q * omag;
  assign phi_w   = m_q[57:32] * cmag;
  assign tfull_w = plo_q + {phi_w[31:0], 32'd0};
  always_ff @(posedge clk_i) begin
    if (cmd_i.mq)  m_q   <= mq_w[63:6];
    if (cmd_i.tlo) plo_q <= m_q[31:0] * cmag;
    if (cmd_i.thi) t_q   <= tfull_w[63:16];
  end

  logic        neg_w;
  logic [63:0] ani_w, tmag_w, term_w;
  logic [63:0] cx_q, cy_q, coin_w;
  logic [7:0]  coin_a;
  assign neg_w  = (cmd_i.axis ? yneg_q : xneg_q) ^ oma_neg ^ scale_q[31];
  assign ani_w  = cmd_i.axis ? {{32{ani_y_q[31]}}, ani_y_q} : {{32{ani_x_q[31]}}, ani_x_q};
  assign tmag_w = {16'd0, t_q};
  assign term_w = ani_w + (neg_w ? (64'd0 - tmag_w) : tmag_w);
  assign coin_a = (a_pair_q >= 8'd64) ? a_pair_q : (8'd64 - a_pair_q);
  assign coin_w = {46'd0, coin_a, 10'd0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.zero_contrib) begin
      cx_q <= '0;
      cy_q <= '0;
    end else if (cmd_i.coin_contrib) begin
      cx_q <= coin_w;
      cy_q <= coin_w;
    end else if (cmd_i.sgn) begin
      if (cmd_i.axis) cy_q <= term_w;
      else            cx_q <= term_w;
    end
  end

  // accumulators
  logic [47:0] accx_q, accy_q;
  logic [7:0]  cnt_q;
  logic [63:0] sumx_w, sumy_w;

  function automatic logic [47:0] sat48(logic [63:0] s);
    logic [47:0] r;
    if (!s[63] && (s[62:47] != '0))      r = {1'b0, {47{1'b1}}};
    else if (s[63] && (s[62:47] != '1))  r = {1'b1, 47'd0};
    else                                 r = s[47:0];
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic [47:0] s);
    logic [31:0] r;
    if (!s[47] && (s[46:31] != '0))      r = 32'h7FFF_FFFF;
    else if (s[47] && (s[46:31] != '1))  r = 32'h8000_0000;
    else                                 r = s[31:0];
    return r;
  endfunction

  assign sumx_w = {{16{accx_q[47]}}, accx_q} + cx_q;
  assign sumy_w = {{16{accy_q[47]}}, accy_q} + cy_q;

  logic [31:0] fx_q, fy_q;
  logic [7:0]  ncnt_q;
  logic        few_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accx_q <= '0;
      accy_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.emit) begin
      accx_q <= '0;
      accy_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.acc_add) begin
      accx_q <= sat48(sumx_w);
      accy_q <= sat48(sumy_w);
      if (cnt_q != 8'hFF) cnt_q <= cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fx_q   <= sat32(accx_q);
      fy_q   <= sat32(accy_q);
      ncnt_q <= cnt_q;
      few_q  <= ({1'b0, cnt_q} < 9'(IDEAL_NEIGHBORS));
    end
  end

  assign out_tdata_o = {7'd0, few_q, ncnt_q, fy_q, fx_q};

  assign sts_o.skip       = skip_q;
  assign sts_o.last       = last_q;
  assign sts_o.coincident = (ax_q == '0) && (ay_q == '0);
  assign sts_o.in_box     = (ax_q <= {2'b00, radius_q}) && (ay_q <= {2'b00, radius_q});
  assign sts_o.in_radius  = (dsq_q <= rsq_q);

endmodule

@@ hw/rtl/pairwise_repulsion_force_sum.sv @@
// top level of the pairwise repulsion force sum block
//
// Takes one cell pair per input transaction on the s_axis channel and adds the
// repulsive displacement on the processed cell into 48-bit saturating sums.
// Pairs marked as self add nothing and are not counted. When a transaction
// carries tlast, one result transaction follows on m_axis with both sums
// clamped to 32 bits, the neighbor count and the few-neighbors flag, and the
// sums and count clear for the next cell.
// One pair at a time: a skipped pair adds nothing, a coincident pair adds a
// push set by adhesion, an out-of-range pair adds zero, and an in-range pair
// runs the 32-step square root and a 62-step divide per axis, one divider.
// A result waits in an output register while the next pairs are processed;
// if a new tlast arrives while it is still not taken, the block holds until
// m_axis_tready. Reset clears sums, count and handshakes and loads the
// register defaults (radius 1.0, gain 1.0). Configuration is written with
// cfg_we_i, cfg_idx_i and cfg_wdata_i while no transaction is in flight.
`timescale 1ns / 1ps
module pairwise_repulsion_force_sum #(
  parameter int unsigned NUM_TYPES       = rprf_pkg::NumTypesDef,
  parameter int unsigned IDEAL_NEIGHBORS = rprf_pkg::IdealNbrDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rprf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rprf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // self_x, self_y, other_x, other_y
  input  logic [rprf_pkg::InDataW-1:0]    s_axis_tdata,
  // self_kind, other_kind, skip_pair
  input  logic [rprf_pkg::InUserW-1:0]    s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // force_x, force_y, neighbor_count, few_neighbors, zero pad
  output logic [rprf_pkg::OutDataW-1:0]   m_axis_tdata
);

  rprf_pkg::cmd_t cmd;
  rprf_pkg::sts_t sts;

  rprf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rprf_dpath #(
    .NUM_TYPES       (NUM_TYPES),
    .IDEAL_NEIGHBORS (IDEAL_NEIGHBORS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .in_tlast_i  (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_tdata_o (m_axis_tdata)
  );

  // a new result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten while stalled");

  // iteration steps, accumulation and emission never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.sqrt_step, cmd.div_step, cmd.acc_add, cmd.emit}))
    else $error("datapath commands overlap");

  // input is taken only when no pair is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.acc_add || cmd.sqrt_step || cmd.div_step))
    else $error("input ready while busy");

  // an emitted result shows up as valid in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid)
    else $error("emitted result not presented");

endmodule
